/* hdl/bdll_pkg.sv */
package bdll_pkg;

   localparam int CAPACITY = 64;
   localparam int VALUE_W  = 32;
   localparam int WORD_W   = 32;
   localparam int POS_W    = 7;
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   // common width for position checks against the element count
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [2:0] {
      FN_ADD_FRONT = 3'd0,
      FN_ADD_BACK  = 3'd1,
      FN_INSERT    = 3'd2,
      FN_REM_FRONT = 3'd3,
      FN_REM_BACK  = 3'd4,
      FN_REM_POS   = 3'd5,
      FN_SEARCH    = 3'd6,
      FN_READ      = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_PLACE,
      ST_WALK,
      ST_FIX_PRV,
      ST_FIX_NXT,
      ST_NEW_NODE,
      ST_REM_HEAD,
      ST_REM_TAIL,
      ST_REM_P,
      ST_REM_Q,
      ST_FREE
   } state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] val;
      logic [SLOT_W-1:0]  nxt;
      logic [SLOT_W-1:0]  prv;
   } node_type;

   function automatic logic [VALUE_W-1:0] to_store(input logic signed [WORD_W-1:0] w);
      return VALUE_W'(w);
   endfunction

   function automatic logic signed [WORD_W-1:0] to_word(input logic [VALUE_W-1:0] s);
      return WORD_W'($signed(s));
   endfunction

endpackage

/* hdl/bdll_ram.sv */
module bdll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read-first: a read of the address being written returns the old word
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* hdl/bounded_doubly_linked_list.sv */
// Channel   Ports                                   Handshake
// -------   -------------------------------------   ------------------------------
// request   req_func, req_item_value, req_position  taken when start && !busy
// result    rsp_status, rsp_found, rsp_found_position,
//           rsp_read_value, rsp_element_count       one cycle, marked by rsp_strobe
//
// A rejected request (full, empty, bad position) gives its word in the cycle after start.
// Front/back adds and removes need no walk; positional insert and remove away from the
// ends, read and search walk the chain in the node RAM, one link per cycle. busy drops
// in the cycle the result word is shown, so the next request can start then. Reset is
// synchronous; the node RAM needs no clearing pass since only linked slots are read.
// The receiver cannot stall results.
module bounded_doubly_linked_list
   import bdll_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_func,
   input  logic signed [WORD_W-1:0] req_item_value,
   input  logic [POS_W-1:0]         req_position,
   output logic                     rsp_strobe,
   output logic [1:0]               rsp_status,
   output logic                     rsp_found,
   output logic [POS_W-1:0]         rsp_found_position,
   output logic signed [WORD_W-1:0] rsp_read_value,
   output logic [POS_W-1:0]         rsp_element_count
);

   state_type state_ff, state_in;

   logic [SLOT_W-1:0]  head_ff, head_in;
   logic [SLOT_W-1:0]  tail_ff, tail_in;
   logic [SLOT_W-1:0]  free_head_ff, free_head_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   fresh_ff, fresh_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [SLOT_W-1:0]  tgt_ff, tgt_in;
   logic [SLOT_W-1:0]  new_slot_ff, new_slot_in;
   logic [SLOT_W-1:0]  slot_a_ff, slot_a_in;
   logic [SLOT_W-1:0]  link_p_ff, link_p_in;
   logic [SLOT_W-1:0]  link_q_ff, link_q_in;
   logic [CNT_W-1:0]   kpos_ff, kpos_in;
   func_type           func_ff, func_in;
   logic [VALUE_W-1:0] val_ff, val_in;

   logic                     rsp_strobe_ff, rsp_strobe_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]         rsp_fpos_ff, rsp_fpos_in;
   logic signed [WORD_W-1:0] rsp_rval_ff, rsp_rval_in;
   logic [POS_W-1:0]         rsp_count_ff;

   logic                      ram_we;
   logic [SLOT_W-1:0]         ram_waddr, ram_raddr;
   logic [$bits(node_type)-1:0] ram_rdata;
   node_type                  rd_node, wr_node;

   bdll_ram #(
      .WIDTH ($bits(node_type)),
      .DEPTH (CAPACITY)
   ) u_node_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_node),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_node = node_type'(ram_rdata);

   // request decode
   func_type          req_fn;
   logic              accept;
   logic              list_full, list_empty;
   logic [CMP_W-1:0]  pos_c, len_c;
   logic              pos_ins_bad, pos_bad;
   logic [CNT_W-1:0]  pos_k;
   logic              dec_err;
   status_type        dec_status;
   logic [CNT_W-1:0]  dec_k;
   logic              acc_insert, acc_remove, ff_insert;
   logic              rm_only, rm_front, rm_back;
   logic              pl_empty, pl_front, pl_back;
   logic              fresh_avail;
   logic              walk_match, walk_last, walk_at, walk_done;

   assign req_fn      = func_type'(req_func);
   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign list_full   = (len_ff == CNT_W'(CAPACITY));
   assign list_empty  = (len_ff == '0);
   assign pos_c       = CMP_W'(req_position);
   assign len_c       = CMP_W'(len_ff);
   assign pos_ins_bad = (pos_c < CMP_W'(1)) || (pos_c > len_c + CMP_W'(1));
   assign pos_bad     = (pos_c < CMP_W'(1)) || (pos_c > len_c);
   assign pos_k       = CNT_W'(pos_c - CMP_W'(1));

   assign acc_insert = (req_fn == FN_ADD_FRONT) || (req_fn == FN_ADD_BACK) ||
                       (req_fn == FN_INSERT);
   assign acc_remove = (req_fn == FN_REM_FRONT) || (req_fn == FN_REM_BACK) ||
                       (req_fn == FN_REM_POS);
   assign ff_insert  = (func_ff == FN_ADD_FRONT) || (func_ff == FN_ADD_BACK) ||
                       (func_ff == FN_INSERT);

   assign rm_only  = (len_ff == CNT_W'(1));
   assign rm_front = (dec_k == '0);
   assign rm_back  = (dec_k == len_ff - CNT_W'(1));

   assign pl_empty = (len_ff == '0);
   assign pl_front = (kpos_ff == '0);
   assign pl_back  = (kpos_ff >= len_ff);

   assign fresh_avail = (fresh_ff < CNT_W'(CAPACITY));

   assign walk_match = (rd_node.val == val_ff);
   assign walk_last  = (CNT_W'(idx_ff) == len_ff - CNT_W'(1));
   assign walk_at    = (idx_ff == tgt_ff);
   assign walk_done  = (func_ff == FN_SEARCH) ? (walk_match || walk_last) : walk_at;

   always_comb begin
      dec_err    = 1'b0;
      dec_status = STAT_OK;
      dec_k      = '0;
      unique case (req_fn)
         FN_ADD_FRONT: begin
            if (list_full) begin
               dec_err    = 1'b1;
               dec_status = STAT_FULL;
            end
         end
         FN_ADD_BACK: begin
            dec_k = len_ff;
            if (list_full) begin
               dec_err    = 1'b1;
               dec_status = STAT_FULL;
            end
         end
         FN_INSERT: begin
            dec_k = pos_k;
            priority if (list_full) begin
               dec_err    = 1'b1;
               dec_status = STAT_FULL;
            end else if (pos_ins_bad) begin
               dec_err    = 1'b1;
               dec_status = STAT_RANGE;
            end
         end
         FN_REM_FRONT: begin
            if (list_empty) begin
               dec_err    = 1'b1;
               dec_status = STAT_EMPTY;
            end
         end
         FN_REM_BACK: begin
            dec_k = len_ff - CNT_W'(1);
            if (list_empty) begin
               dec_err    = 1'b1;
               dec_status = STAT_EMPTY;
            end
         end
         FN_REM_POS, FN_READ: begin
            dec_k = pos_k;
            priority if (list_empty) begin
               dec_err    = 1'b1;
               dec_status = STAT_EMPTY;
            end else if (pos_bad) begin
               dec_err    = 1'b1;
               dec_status = STAT_RANGE;
            end
         end
         FN_SEARCH: begin
            if (list_empty) begin
               dec_err    = 1'b1;
               dec_status = STAT_EMPTY;
            end
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (dec_err) begin
                  state_in = ST_IDLE;
               end else if (acc_insert) begin
                  state_in = fresh_avail ? ST_PLACE : ST_ALLOC;
               end else if (acc_remove) begin
                  priority if (rm_only) begin
                     state_in = ST_FREE;
                  end else if (rm_front) begin
                     state_in = ST_REM_HEAD;
                  end else if (rm_back) begin
                     state_in = ST_REM_TAIL;
                  end else begin
                     state_in = ST_WALK;
                  end
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_ALLOC: state_in = ST_PLACE;
         ST_PLACE: begin
            priority if (pl_empty) begin
               state_in = ST_NEW_NODE;
            end else if (pl_front) begin
               state_in = ST_FIX_PRV;
            end else if (pl_back) begin
               state_in = ST_FIX_NXT;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               priority if ((func_ff == FN_SEARCH) || (func_ff == FN_READ)) begin
                  state_in = ST_IDLE;
               end else if (ff_insert) begin
                  state_in = ST_FIX_PRV;
               end else begin
                  state_in = ST_REM_P;
               end
            end
         end
         ST_FIX_PRV:  state_in = ST_NEW_NODE;
         ST_FIX_NXT:  state_in = ST_NEW_NODE;
         ST_NEW_NODE: state_in = ST_IDLE;
         ST_REM_HEAD: state_in = ST_FREE;
         ST_REM_TAIL: state_in = ST_FREE;
         ST_REM_P:    state_in = ST_REM_Q;
         ST_REM_Q:    state_in = ST_FREE;
         ST_FREE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath, RAM control and result word
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_head_in  = free_head_ff;
      len_in        = len_ff;
      fresh_in      = fresh_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      tgt_in        = tgt_ff;
      new_slot_in   = new_slot_ff;
      slot_a_in     = slot_a_ff;
      link_p_in     = link_p_ff;
      link_q_in     = link_q_ff;
      kpos_in       = kpos_ff;
      func_in       = func_ff;
      val_in        = val_ff;
      ram_we        = 1'b0;
      ram_waddr     = slot_a_ff;
      ram_raddr     = cur_ff;
      wr_node       = '0;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_found_in  = 1'b0;
      rsp_fpos_in   = '0;
      rsp_rval_in   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in = req_fn;
               val_in  = to_store(req_item_value);
               kpos_in = dec_k;
               cur_in  = head_ff;
               idx_in  = '0;
               tgt_in  = SLOT_W'(dec_k);
               priority if (dec_err) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = dec_status;
               end else if (acc_insert) begin
                  if (fresh_avail) begin
                     new_slot_in = SLOT_W'(fresh_ff);
                     fresh_in    = fresh_ff + CNT_W'(1);
                  end else begin
                     ram_raddr = free_head_ff;
                  end
               end else if (acc_remove) begin
                  slot_a_in = rm_front ? head_ff : tail_ff;
                  ram_raddr = (rm_back && !rm_front) ? tail_ff : head_ff;
               end else begin
                  ram_raddr = head_ff;
               end
            end
         end
         ST_ALLOC: begin
            new_slot_in  = free_head_ff;
            free_head_in = rd_node.nxt;
         end
         ST_PLACE: begin
            priority if (pl_empty) begin
               link_p_in = '0;
               link_q_in = '0;
            end else if (pl_front) begin
               ram_raddr = head_ff;
               slot_a_in = head_ff;
               link_q_in = head_ff;
               link_p_in = '0;
            end else if (pl_back) begin
               ram_raddr = tail_ff;
               slot_a_in = tail_ff;
               link_p_in = tail_ff;
               link_q_in = '0;
            end else begin
               ram_raddr = head_ff;
               cur_in    = head_ff;
               idx_in    = '0;
               tgt_in    = SLOT_W'(kpos_ff - CNT_W'(1));
            end
         end
         ST_WALK: begin
            if (!walk_done) begin
               ram_raddr = rd_node.nxt;
               cur_in    = rd_node.nxt;
               idx_in    = idx_ff + SLOT_W'(1);
            end else begin
               unique case (func_ff)
                  FN_SEARCH: begin
                     rsp_strobe_in = 1'b1;
                     if (walk_match) begin
                        rsp_found_in = 1'b1;
                        rsp_fpos_in  = POS_W'(CNT_W'(idx_ff) + CNT_W'(1));
                     end
                  end
                  FN_READ: begin
                     rsp_strobe_in = 1'b1;
                     rsp_rval_in   = to_word(rd_node.val);
                  end
                  FN_ADD_FRONT, FN_ADD_BACK, FN_INSERT: begin
                     // cur is the predecessor: link it forward to the new node
                     ram_we      = 1'b1;
                     ram_waddr   = cur_ff;
                     wr_node.val = rd_node.val;
                     wr_node.nxt = new_slot_ff;
                     wr_node.prv = rd_node.prv;
                     slot_a_in   = rd_node.nxt;
                     ram_raddr   = rd_node.nxt;
                     link_q_in   = rd_node.nxt;
                     link_p_in   = cur_ff;
                  end
                  FN_REM_FRONT, FN_REM_BACK, FN_REM_POS: begin
                     slot_a_in = cur_ff;
                     link_p_in = rd_node.prv;
                     link_q_in = rd_node.nxt;
                     ram_raddr = rd_node.prv;
                  end
               endcase
            end
         end
         ST_FIX_PRV: begin
            ram_we      = 1'b1;
            wr_node.val = rd_node.val;
            wr_node.nxt = rd_node.nxt;
            wr_node.prv = new_slot_ff;
         end
         ST_FIX_NXT: begin
            ram_we      = 1'b1;
            wr_node.val = rd_node.val;
            wr_node.nxt = new_slot_ff;
            wr_node.prv = rd_node.prv;
         end
         ST_NEW_NODE: begin
            ram_we      = 1'b1;
            ram_waddr   = new_slot_ff;
            wr_node.val = val_ff;
            wr_node.nxt = link_q_ff;
            wr_node.prv = link_p_ff;
            priority if (pl_empty) begin
               head_in = new_slot_ff;
               tail_in = new_slot_ff;
            end else if (pl_front) begin
               head_in = new_slot_ff;
            end else if (pl_back) begin
               tail_in = new_slot_ff;
            end
            len_in        = len_ff + CNT_W'(1);
            rsp_strobe_in = 1'b1;
         end
         ST_REM_HEAD: head_in = rd_node.nxt;
         ST_REM_TAIL: tail_in = rd_node.prv;
         ST_REM_P: begin
            ram_we      = 1'b1;
            ram_waddr   = link_p_ff;
            wr_node.val = rd_node.val;
            wr_node.nxt = link_q_ff;
            wr_node.prv = rd_node.prv;
            ram_raddr   = link_q_ff;
         end
         ST_REM_Q: begin
            ram_we      = 1'b1;
            ram_waddr   = link_q_ff;
            wr_node.val = rd_node.val;
            wr_node.nxt = rd_node.nxt;
            wr_node.prv = link_p_ff;
         end
         ST_FREE: begin
            // freed slot joins the free chain through its next link
            ram_we        = 1'b1;
            wr_node.nxt   = free_head_ff;
            free_head_in  = slot_a_ff;
            len_in        = len_ff - CNT_W'(1);
            rsp_strobe_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_head_ff  <= '0;
         len_ff        <= '0;
         fresh_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_head_ff  <= free_head_in;
         len_ff        <= len_in;
         fresh_ff      <= fresh_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      tgt_ff      <= tgt_in;
      new_slot_ff <= new_slot_in;
      slot_a_ff   <= slot_a_in;
      link_p_ff   <= link_p_in;
      link_q_ff   <= link_q_in;
      kpos_ff     <= kpos_in;
      func_ff     <= func_in;
      val_ff      <= val_in;
      if (rsp_strobe_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_fpos_ff   <= rsp_fpos_in;
         rsp_rval_ff   <= rsp_rval_in;
         rsp_count_ff  <= POS_W'(len_in);
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_read_value     = rsp_rval_ff;
   assign rsp_element_count  = rsp_count_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (len_ff <= CNT_W'(CAPACITY)) && (len_ff <= fresh_ff))
      else $error("element count beyond capacity or allocated slots");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result word shown while busy");

   a_reject_fast: assert property (@(posedge clock) disable iff (reset)
      (accept && dec_err) |=> (rsp_strobe && (len_ff == $past(len_ff))))
      else $error("rejected request did not answer next cycle");

   a_free_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FREE) |=> (len_ff == $past(len_ff) - CNT_W'(1)))
      else $error("remove did not drop the element count");

endmodule
